>>> rtl/core/alsmu_pkg.sv
// Shared definitions for the load/store memory unit: command and fault codes,
// the load-format selector and the stage control record.
// No dependencies.
`timescale 1ns / 1ps

package alsmu_pkg;

   // Default memory size in address bits (bytes = 2**ADDR_BITS)
   localparam int ADDR_BITS_DEFAULT = 16;

   localparam int CMD_BITS   = 4;
   localparam int FAULT_BITS = 2;
   localparam int DATA_BITS  = 64;
   localparam int WORD_BITS  = 32;
   localparam int LANES      = 4;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_FETCH        = 4'd0;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_WORD    = 4'd1;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_HALF    = 4'd2;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_BYTE    = 4'd3;
   localparam logic [CMD_BITS-1:0] CMD_LOAD_DOUBLE  = 4'd4;
   localparam logic [CMD_BITS-1:0] CMD_STORE_WORD   = 4'd5;
   localparam logic [CMD_BITS-1:0] CMD_STORE_HALF   = 4'd6;
   localparam logic [CMD_BITS-1:0] CMD_STORE_BYTE   = 4'd7;
   localparam logic [CMD_BITS-1:0] CMD_STORE_DOUBLE = 4'd8;

   // Fault codes
   localparam logic [FAULT_BITS-1:0] FAULT_NONE  = 2'd0;
   localparam logic [FAULT_BITS-1:0] FAULT_FETCH = 2'd1;
   localparam logic [FAULT_BITS-1:0] FAULT_STORE = 2'd2;

   // How the read words turn into the response value
   typedef enum logic [2:0] {
      FMT_NONE,
      FMT_FETCH,
      FMT_WORD,
      FMT_HALF,
      FMT_BYTE,
      FMT_DOUBLE
   } fmt_type;

   // Control carried alongside the memory read
   typedef struct packed {
      fmt_type                kind;
      logic [2:0]             offset;
      logic [FAULT_BITS-1:0]  fault;
   } ctrl_type;

endpackage

>>> rtl/core/alsmu_bank.sv
// One 32-bit memory bank with byte write enables and a registered read port.
// Depends on alsmu_pkg.
`timescale 1ns / 1ps

module alsmu_bank
   import alsmu_pkg::*;
#(
   parameter int ROW_BITS = ADDR_BITS_DEFAULT - 3
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ROW_BITS-1:0]  wr_row,
   input  logic [LANES-1:0]     wr_be,
   input  logic [WORD_BITS-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [ROW_BITS-1:0]  rd_row,
   output logic [WORD_BITS-1:0] rd_data
);

   logic [WORD_BITS-1:0] mem_ff [2**ROW_BITS];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write the enabled byte lanes
   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int i = 0; i < LANES; i++) begin
            if (wr_be[i]) begin
               mem_ff[wr_row][8*i +: 8] <= wr_data[8*i +: 8];
            end
         end
      end
   end

   // Read one row, hold the data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_row];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/alsmu_format.sv
// Load formatting: picks the low and high words from the two banks and applies
// rotation, halfword swap, byte select and doubleword join. Depends on alsmu_pkg.
`timescale 1ns / 1ps

module alsmu_format
   import alsmu_pkg::*;
(
   input  ctrl_type             ctrl,
   input  logic [WORD_BITS-1:0] bank0_data,
   input  logic [WORD_BITS-1:0] bank1_data,
   output logic [DATA_BITS-1:0] read_data
);

   // Rotate right by eight bits per byte of offset
   function automatic logic [WORD_BITS-1:0] rotate_word(logic [WORD_BITS-1:0] w,
                                                        logic [1:0] off);
      logic [WORD_BITS-1:0] r;
      unique case (off)
         2'd0:    r = w;
         2'd1:    r = {w[7:0],  w[31:8]};
         2'd2:    r = {w[15:0], w[31:16]};
         default: r = {w[23:0], w[31:24]};
      endcase
      return r;
   endfunction

   logic [WORD_BITS-1:0] lo_word;
   logic [WORD_BITS-1:0] hi_word;
   logic [15:0]          half;
   logic [7:0]           byte_val;

   // Word at the address sits in bank selected by address bit 2
   assign lo_word = ctrl.offset[2] ? bank1_data : bank0_data;
   assign hi_word = ctrl.offset[2] ? bank0_data : bank1_data;

   // Swap the aligned halfword on an odd address
   always_comb begin
      half = ctrl.offset[1] ? lo_word[31:16] : lo_word[15:0];
      if (ctrl.offset[0]) begin
         half = {half[7:0], half[15:8]};
      end
   end

   always_comb begin
      unique case (ctrl.offset[1:0])
         2'd0:    byte_val = lo_word[7:0];
         2'd1:    byte_val = lo_word[15:8];
         2'd2:    byte_val = lo_word[23:16];
         default: byte_val = lo_word[31:24];
      endcase
   end

   // Build the zero-extended response value
   always_comb begin
      unique case (ctrl.kind)
         FMT_FETCH:  read_data = {32'd0, lo_word};
         FMT_WORD:   read_data = {32'd0, rotate_word(lo_word, ctrl.offset[1:0])};
         FMT_HALF:   read_data = {48'd0, half};
         FMT_BYTE:   read_data = {56'd0, byte_val};
         FMT_DOUBLE: read_data = {rotate_word(hi_word, ctrl.offset[1:0]),
                                  rotate_word(lo_word, ctrl.offset[1:0])};
         default:    read_data = '0;
      endcase
   end

endmodule

>>> rtl/core/arm_load_store_memory_unit.sv
// Top level of the load/store memory unit: request decode, two word banks,
// load formatting and the response register. Depends on alsmu_pkg, alsmu_bank,
// alsmu_format.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  command, address, write_data
//   rsp_      out        rsp_valid/rsp_stall  read_data, fault
//
// One request per cycle while req_stall is low; a request passes through the
// bank read registers at the accepting edge, then formatting into the response
// register. Even and odd words sit in separate banks, so a doubleword takes
// one access of both bank ports. Reset clears only the valid flags; memory
// contents are undefined until written and get no clearing pass. A stalled
// response backs up the read stage, which then stalls requests.
`timescale 1ns / 1ps

module arm_load_store_memory_unit
   import alsmu_pkg::*;
#(
   parameter int ADDR_BITS = ADDR_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CMD_BITS-1:0]   req_command,
   input  logic [ADDR_BITS-1:0]  req_address,
   input  logic [DATA_BITS-1:0]  req_write_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_BITS-1:0]  rsp_read_data,
   output logic [FAULT_BITS-1:0] rsp_fault
);

   localparam int ROW_BITS = ADDR_BITS - 3;

   logic                 req_accept;
   logic                 rsp_blocked;
   logic                 s1_advance;

   ctrl_type             ctrl_in;
   logic                 is_load;
   logic                 is_store;
   logic                 is_double;
   logic [LANES-1:0]     store_be;
   logic [WORD_BITS-1:0] lo_data;
   logic [WORD_BITS-1:0] hi_data;

   logic [ROW_BITS-1:0]  row;
   logic [ROW_BITS-1:0]  bank0_row;
   logic                 bank0_wr_en;
   logic                 bank1_wr_en;
   logic [LANES-1:0]     bank0_be;
   logic [LANES-1:0]     bank1_be;
   logic [WORD_BITS-1:0] bank0_wr_data;
   logic [WORD_BITS-1:0] bank1_wr_data;
   logic [WORD_BITS-1:0] bank0_rd_data;
   logic [WORD_BITS-1:0] bank1_rd_data;
   logic                 rd_en;

   logic                 s1_valid_ff, s1_valid_in;
   ctrl_type             s1_ctrl_ff;
   logic [DATA_BITS-1:0] fmt_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_read_data_ff;
   logic [FAULT_BITS-1:0] rsp_fault_ff;

   // Handshake
   assign rsp_blocked = rsp_valid_ff && rsp_stall;
   assign req_stall   = s1_valid_ff && rsp_blocked;
   assign req_accept  = req_valid && !req_stall;
   assign s1_advance  = s1_valid_ff && !rsp_blocked;

   // Decode the request into load format, store lanes and fault
   always_comb begin
      ctrl_in.kind   = FMT_NONE;
      ctrl_in.offset = req_address[2:0];
      ctrl_in.fault  = FAULT_NONE;
      is_load        = 1'b0;
      is_store       = 1'b0;
      is_double      = 1'b0;
      store_be       = '0;
      lo_data        = req_write_data[31:0];
      hi_data        = req_write_data[63:32];
      unique case (req_command)
         CMD_FETCH: begin
            if (req_address[1:0] != 2'd0) begin
               ctrl_in.fault = FAULT_FETCH;
            end else begin
               ctrl_in.kind = FMT_FETCH;
               is_load      = 1'b1;
            end
         end
         CMD_LOAD_WORD: begin
            ctrl_in.kind = FMT_WORD;
            is_load      = 1'b1;
         end
         CMD_LOAD_HALF: begin
            ctrl_in.kind = FMT_HALF;
            is_load      = 1'b1;
         end
         CMD_LOAD_BYTE: begin
            ctrl_in.kind = FMT_BYTE;
            is_load      = 1'b1;
         end
         CMD_LOAD_DOUBLE: begin
            ctrl_in.kind = FMT_DOUBLE;
            is_load      = 1'b1;
         end
         CMD_STORE_WORD: begin
            if (req_address[1:0] != 2'd0) begin
               ctrl_in.fault = FAULT_STORE;
            end else begin
               is_store = 1'b1;
               store_be = 4'b1111;
               hi_data  = req_write_data[31:0];
            end
         end
         CMD_STORE_HALF: begin
            if (req_address[0]) begin
               ctrl_in.fault = FAULT_STORE;
            end else begin
               is_store = 1'b1;
               store_be = {req_address[1], req_address[1],
                           !req_address[1], !req_address[1]};
               lo_data  = {2{req_write_data[15:0]}};
               hi_data  = lo_data;
            end
         end
         CMD_STORE_BYTE: begin
            is_store = 1'b1;
            store_be = 4'b0001 << req_address[1:0];
            lo_data  = {4{req_write_data[7:0]}};
            hi_data  = lo_data;
         end
         CMD_STORE_DOUBLE: begin
            if (req_address[1:0] != 2'd0) begin
               ctrl_in.fault = FAULT_STORE;
            end else begin
               is_store  = 1'b1;
               is_double = 1'b1;
               store_be  = 4'b1111;
            end
         end
         default: begin
            ctrl_in.kind = FMT_NONE;
         end
      endcase
   end

   // Map word index to bank and row; the next word wraps through bank 0
   assign row       = req_address[ADDR_BITS-1:3];
   assign bank0_row = row + ROW_BITS'(req_address[2]);

   assign bank0_wr_en   = req_accept && is_store && (is_double || !req_address[2]);
   assign bank1_wr_en   = req_accept && is_store && (is_double || req_address[2]);
   assign bank0_be      = store_be;
   assign bank1_be      = store_be;
   assign bank0_wr_data = req_address[2] ? hi_data : lo_data;
   assign bank1_wr_data = req_address[2] ? lo_data : hi_data;
   assign rd_en         = req_accept && is_load;

   alsmu_bank #(
      .ROW_BITS (ROW_BITS)
   ) u_bank0 (
      .clock   (clock),
      .wr_en   (bank0_wr_en),
      .wr_row  (bank0_row),
      .wr_be   (bank0_be),
      .wr_data (bank0_wr_data),
      .rd_en   (rd_en),
      .rd_row  (bank0_row),
      .rd_data (bank0_rd_data)
   );

   alsmu_bank #(
      .ROW_BITS (ROW_BITS)
   ) u_bank1 (
      .clock   (clock),
      .wr_en   (bank1_wr_en),
      .wr_row  (row),
      .wr_be   (bank1_be),
      .wr_data (bank1_wr_data),
      .rd_en   (rd_en),
      .rd_row  (row),
      .rd_data (bank1_rd_data)
   );

   alsmu_format u_format (
      .ctrl       (s1_ctrl_ff),
      .bank0_data (bank0_rd_data),
      .bank1_data (bank1_rd_data),
      .read_data  (fmt_data)
   );

   // Read stage: hold while the response register is blocked
   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ctrl_ff <= ctrl_in;
      end
   end

   // Response register: load when empty or taken
   assign rsp_valid_in = rsp_blocked ? 1'b1 : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_read_data_ff <= fmt_data;
         rsp_fault_ff     <= s1_ctrl_ff.fault;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_fault     = rsp_fault_ff;

`ifndef SYNTHESIS
   // A blocked read stage keeps its request
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_blocked |=> s1_valid_ff)
      else $error("read stage dropped a request while blocked");

   // A faulting response carries zero data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fault_ff != FAULT_NONE |-> rsp_read_data_ff == '0)
      else $error("fault response with nonzero data");

   // Memory is written only by an accepted store
   assert property (@(posedge clock) disable iff (reset)
      bank0_wr_en || bank1_wr_en |-> req_valid && !req_stall && ctrl_in.fault == FAULT_NONE)
      else $error("memory write without an accepted store");

   // Loads and stores never use the banks in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !bank0_wr_en && !bank1_wr_en)
      else $error("bank read and write in the same cycle");
`endif

endmodule
